@@ rtl/fst_pkg.sv @@
// Shared constants, codes and types for the prefix sum tree unit.
package fst_pkg;

    localparam int DEF_MAX_POSITIONS = 1024;
    localparam int SIZE_W            = 11;
    localparam int KIND_W            = 2;
    localparam int DATA_W            = 32;

    localparam logic [SIZE_W-1:0] TREE_SIZE_RST = SIZE_W'(1024);

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_SUM   = 4'b1000
    } t_state;

endpackage

@@ rtl/prefix_sum_tree_unit.sv @@
// Top level of the prefix sum tree unit: size register, sequencer and store.
//
//   channel   direction  handshake                     payload
//   request   in         start & !busy                 i_kind, i_position, i_delta
//   result    out        o_result_valid (one cycle)    o_prefix_total
//   config    in         i_cfg_we                      i_cfg_wdata (tree size)
//
// Add and query visit the tree nodes one after another; the single read port
// and single write port of the store set this pace.
// Clear, and reset, sweep the store one entry a cycle over all MAX_POSITIONS
// entries with busy high; the size register still takes writes.
// Results come in the cycle after the walk ends and are never held back.
module prefix_sum_tree_unit
    import fst_pkg::*;
#(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [SIZE_W-1:0]        i_position,
    input  logic signed [DATA_W-1:0] i_delta,
    output logic                     o_result_valid,
    output logic signed [DATA_W-1:0] o_prefix_total,
    input  logic                     i_cfg_we,
    input  logic [SIZE_W-1:0]        i_cfg_wdata
);

    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int IW = $clog2(MAX_POSITIONS + 1) + 1;

    logic [SIZE_W-1:0] r_tree_size;
    logic [IW-1:0]     size_n;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rd_data, total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_size <= TREE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_tree_size <= i_cfg_wdata;
        end
    end

    // limit the walk to the store depth
    assign size_n = (32'(r_tree_size) > 32'(MAX_POSITIONS)) ? IW'(MAX_POSITIONS)
                                                             : IW'(r_tree_size);

    fst_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .AW            (AW),
        .IW            (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_delta    (i_delta),
        .i_size_n   (size_n),
        .o_busy     (busy),
        .o_valid    (o_result_valid),
        .o_total    (total),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rd_data  (rd_data)
    );

    fst_mem #(
        .DEPTH (MAX_POSITIONS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr   (raddr),
        .o_rd_data (rd_data)
    );

    assign o_prefix_total = total;

endmodule

@@ rtl/fst_mem.sv @@
// Partial sum store: one write port, one registered read port.
module fst_mem
    import fst_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POSITIONS,
    parameter int AW    = $clog2(DEF_MAX_POSITIONS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/fst_ctrl.sv @@
// Tree walk sequencer: clear sweep, upward add walk, downward prefix sum walk.
module fst_ctrl
    import fst_pkg::*;
#(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
    parameter int AW            = $clog2(DEF_MAX_POSITIONS),
    parameter int IW            = $clog2(DEF_MAX_POSITIONS + 1) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SIZE_W-1:0] i_position,
    input  logic [DATA_W-1:0] i_delta,
    input  logic [IW-1:0]     i_size_n,
    output logic              o_busy,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_total,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [DATA_W-1:0] i_rd_data
);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_clr, n_clr;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_delta, n_delta;
    logic [DATA_W-1:0] r_total, n_total;
    logic              r_out_valid, n_out_valid;

    logic              pos_big;
    logic [IW-1:0]     pos_clamp;
    logic [IW-1:0]     up_idx;
    logic [IW-1:0]     down_idx;
    logic [IW-1:0]     rd_idx;
    logic [DATA_W-1:0] acc_sum;

    assign pos_big   = 32'(i_position) > 32'(i_size_n);
    assign pos_clamp = pos_big ? i_size_n : IW'(i_position);
    assign up_idx    = r_idx + (r_idx & (~r_idx + IW'(1)));
    assign down_idx  = r_idx & (r_idx - IW'(1));
    assign acc_sum   = r_acc + i_rd_data;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_clr       = r_clr;
        n_acc       = r_acc;
        n_delta     = r_delta;
        n_total     = r_total;
        n_out_valid = 1'b0;
        rd_idx      = r_idx;
        o_re        = 1'b0;
        o_we        = 1'b0;
        o_waddr     = AW'(r_idx - IW'(1));
        o_wdata     = i_rd_data + r_delta;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        KIND_ADD: begin
                            // drop adds at position zero or past the size
                            if (i_position != '0 && !pos_big) begin
                                rd_idx  = pos_clamp;
                                o_re    = 1'b1;
                                n_idx   = pos_clamp;
                                n_delta = i_delta;
                                n_state = ST_ADD;
                            end
                        end
                        KIND_SUM: begin
                            if (pos_clamp == '0) begin
                                n_total     = '0;
                                n_out_valid = 1'b1;
                            end else begin
                                rd_idx  = pos_clamp;
                                o_re    = 1'b1;
                                n_idx   = pos_clamp;
                                n_acc   = '0;
                                n_state = ST_SUM;
                            end
                        end
                        KIND_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(MAX_POSITIONS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADD: begin
                // write back this node, fetch the parent in the same cycle
                o_we = 1'b1;
                if (up_idx <= i_size_n) begin
                    rd_idx = up_idx;
                    o_re   = 1'b1;
                    n_idx  = up_idx;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: begin
                n_acc = acc_sum;
                if (down_idx != '0) begin
                    rd_idx = down_idx;
                    o_re   = 1'b1;
                    n_idx  = down_idx;
                end else begin
                    n_total     = acc_sum;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_raddr = AW'(rd_idx - IW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_delta <= n_delta;
        r_total <= n_total;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_total = r_total;

    a_add_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_idx != '0 && r_idx <= i_size_n))
        else $error("add walk left the tree");

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_re && o_we) |-> (o_raddr != o_waddr))
        else $error("read and write hit the same entry");

    a_sum_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && down_idx == '0) |=> o_valid)
        else $error("finished query gave no result");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_SUM
                          || (r_state == ST_IDLE && i_start && i_kind == KIND_SUM)))
        else $error("result strobe without a query");

endmodule
